[hdl/bsfc_pkg.sv]
// bsfc_pkg: shared types and constants for the binaural stereo fir convolver
// command codes, register indexes, queued job record and back end states
// no dependencies
`default_nettype none

package bsfc_pkg;

   localparam int DATA_W     = 16;
   localparam int CMD_W      = 2;
   localparam int IDX_W      = 8;
   localparam int DLY_REG_W  = 8;
   localparam int CSR_W      = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CMD_W-1:0] CMD_SAMPLE     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_LEFT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_RIGHT = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE       = 2'd3;

   localparam logic REG_DELAY_LEFT  = 1'b0;
   localparam logic REG_DELAY_RIGHT = 1'b1;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_LOAD_LEFT,
      OP_LOAD_RIGHT
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [IDX_W-1:0]          tap_index;
      logic signed [DATA_W-1:0]  value;
   } job_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_DONE
   } back_state_type;

endpackage

`default_nettype wire

[hdl/bsfc_queue.sv]
// bsfc_queue: two-entry job queue between front and back end
// depends on bsfc_pkg for the job record
`default_nettype none

module bsfc_queue
   import bsfc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  job_type      push_job,
   output logic         full,
   output logic         pop_valid,
   output job_type      pop_job,
   input  wire logic    pop
);

   job_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_job   = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[hdl/bsfc_front.sv]
// bsfc_front: takes input beats, sorts them into jobs and queues them
// depends on bsfc_pkg and bsfc_queue
`default_nettype none

module bsfc_front
   import bsfc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [CMD_W-1:0]         req_cmd,
   input  wire logic [IDX_W-1:0]         req_tap_index,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic                     hold,
   output logic                          job_valid,
   output job_type                       job,
   input  wire logic                     job_pop
);

   logic    full;
   logic    keep;
   job_type new_job;

   always_comb begin
      keep              = 1'b1;
      new_job.op        = OP_SAMPLE;
      new_job.tap_index = req_tap_index;
      new_job.value     = req_value;
      unique case (req_cmd)
         CMD_SAMPLE:     new_job.op = OP_SAMPLE;
         CMD_LOAD_LEFT:  new_job.op = OP_LOAD_LEFT;
         CMD_LOAD_RIGHT: new_job.op = OP_LOAD_RIGHT;
         default:        keep = 1'b0;
      endcase
   end

   assign req_ready = !full && !hold;

   bsfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && req_ready && keep),
      .push_job  (new_job),
      .full      (full),
      .pop_valid (job_valid),
      .pop_job   (job),
      .pop       (job_pop)
   );

endmodule

`default_nettype wire

[hdl/bsfc_back.sv]
// bsfc_back: history and tap memories, two-ear multiply-accumulate engine
// and result register; depends on bsfc_pkg
`default_nettype none

module bsfc_back
   import bsfc_pkg::*;
#(
   parameter int TAPS,
   parameter int MAX_DELAY
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  job_valid,
   input  job_type                    job,
   output logic                       job_pop,
   input  wire logic [DLY_REG_W-1:0]  delay_left,
   input  wire logic [DLY_REG_W-1:0]  delay_right,
   output logic                       hold,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [DATA_W-1:0]   rsp_left_out,
   output logic signed [DATA_W-1:0]   rsp_right_out
);

   localparam int HIST_LEN = TAPS + MAX_DELAY;
   localparam int HA_W     = $clog2(HIST_LEN);
   localparam int FC_W     = $clog2(HIST_LEN + 1);
   localparam int TI_W     = $clog2(TAPS);
   localparam int DLY_W    = (FC_W > DLY_REG_W) ? FC_W : DLY_REG_W;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int ACC_W    = PROD_W + TI_W + 1;
   localparam int FRAC     = DATA_W - 1;

   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (FRAC - 1));
   localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'((1 << FRAC) - 1);
   localparam logic signed [ACC_W-1:0] SAT_MIN  = ACC_W'(-(1 << FRAC));

   logic signed [DATA_W-1:0] hist_mem [HIST_LEN];
   logic signed [DATA_W-1:0] ltap_mem [TAPS];
   logic signed [DATA_W-1:0] rtap_mem [TAPS];

   back_state_type state_ff, state_in;

   logic [TI_W-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [HA_W-1:0]          newest_ff, newest_in;
   logic [FC_W-1:0]          fill_ff, fill_in;
   logic [TI_W-1:0]          tap_cnt_ff, tap_cnt_in;
   logic [HA_W-1:0]          addr_l_ff, addr_l_in;
   logic [HA_W-1:0]          addr_r_ff, addr_r_in;
   logic [FC_W-1:0]          dl_ff, dl_in;
   logic [FC_W-1:0]          dr_ff, dr_in;
   logic                     s1_vld_ff, s1_vld_in;
   logic                     s1_msk_l_ff, s1_msk_l_in;
   logic                     s1_msk_r_ff, s1_msk_r_in;
   logic                     s2_vld_ff, s2_vld_in;
   logic signed [PROD_W-1:0] prod_l_ff, prod_l_in;
   logic signed [PROD_W-1:0] prod_r_ff, prod_r_in;
   logic signed [ACC_W-1:0]  acc_l_ff, acc_l_in;
   logic signed [ACC_W-1:0]  acc_r_ff, acc_r_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] left_out_ff, left_out_in;
   logic signed [DATA_W-1:0] right_out_ff, right_out_in;

   logic signed [DATA_W-1:0] hist_l_ff, hist_r_ff;
   logic signed [DATA_W-1:0] tap_l_ff, tap_r_ff;

   logic                     hist_we;
   logic [HA_W-1:0]          hist_wa;
   logic signed [DATA_W-1:0] hist_wd;
   logic                     ltap_we, rtap_we;
   logic [TI_W-1:0]          tap_wa;
   logic signed [DATA_W-1:0] tap_wd;

   logic [HA_W-1:0]          newest_nx;
   logic [DLY_W-1:0]         dl_c, dr_c;
   logic [FC_W-1:0]          dl_fc, dr_fc;
   logic [HA_W-1:0]          start_l, start_r;
   logic                     idx_ok;
   logic signed [PROD_W-1:0] mul_l, mul_r;
   logic signed [ACC_W-1:0]  rnd_l, rnd_r;
   logic signed [DATA_W-1:0] sat_l, sat_r;

   function automatic logic [HA_W-1:0] wrap_sub(input logic [HA_W-1:0] base,
                                                input logic [FC_W-1:0] off);
      logic [FC_W:0] b;
      logic [FC_W:0] o;
      b = (FC_W + 1)'(base);
      o = (FC_W + 1)'(off);
      if (b >= o) begin
         return HA_W'(b - o);
      end
      return HA_W'(b + (FC_W + 1)'(HIST_LEN) - o);
   endfunction

   function automatic logic signed [DATA_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] r;
      r = (acc + RND_HALF) >>> FRAC;
      if (r > SAT_MAX) begin
         r = SAT_MAX;
      end else if (r < SAT_MIN) begin
         r = SAT_MIN;
      end
      return r[DATA_W-1:0];
   endfunction

   always_comb begin
      newest_nx = (newest_ff == HA_W'(HIST_LEN - 1)) ? '0 : newest_ff + 1'b1;
      dl_c = (DLY_W'(delay_left) > DLY_W'(MAX_DELAY)) ? DLY_W'(MAX_DELAY)
                                                      : DLY_W'(delay_left);
      dr_c = (DLY_W'(delay_right) > DLY_W'(MAX_DELAY)) ? DLY_W'(MAX_DELAY)
                                                       : DLY_W'(delay_right);
      dl_fc   = FC_W'(dl_c);
      dr_fc   = FC_W'(dr_c);
      start_l = wrap_sub(newest_nx, dl_fc);
      start_r = wrap_sub(newest_nx, dr_fc);
      idx_ok  = (32'(job.tap_index) < TAPS);
      mul_l   = tap_l_ff * hist_l_ff;
      mul_r   = tap_r_ff * hist_r_ff;
      rnd_l   = acc_l_ff;
      rnd_r   = acc_r_ff;
      sat_l   = round_sat(rnd_l);
      sat_r   = round_sat(rnd_r);
   end

   // multiply-accumulate pipeline: memory read, product, accumulate
   always_comb begin
      s1_vld_in   = (state_ff == ST_MAC);
      s1_msk_l_in = ((dl_ff + FC_W'(tap_cnt_ff)) < fill_ff);
      s1_msk_r_in = ((dr_ff + FC_W'(tap_cnt_ff)) < fill_ff);
      s2_vld_in   = s1_vld_ff;
      prod_l_in   = s1_msk_l_ff ? mul_l : '0;
      prod_r_in   = s1_msk_r_ff ? mul_r : '0;
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      newest_in    = newest_ff;
      fill_in      = fill_ff;
      tap_cnt_in   = tap_cnt_ff;
      addr_l_in    = addr_l_ff;
      addr_r_in    = addr_r_ff;
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      acc_l_in     = acc_l_ff;
      acc_r_in     = acc_r_ff;
      rsp_valid_in = rsp_valid_ff;
      left_out_in  = left_out_ff;
      right_out_in = right_out_ff;
      job_pop      = 1'b0;
      hold         = 1'b0;
      hist_we      = 1'b0;
      hist_wa      = newest_nx;
      hist_wd      = job.value;
      ltap_we      = 1'b0;
      rtap_we      = 1'b0;
      tap_wa       = TI_W'(job.tap_index);
      tap_wd       = job.value;

      if (s2_vld_ff) begin
         acc_l_in = acc_l_ff + ACC_W'(prod_l_ff);
         acc_r_in = acc_r_ff + ACC_W'(prod_r_ff);
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            hold       = 1'b1;
            ltap_we    = 1'b1;
            rtap_we    = 1'b1;
            tap_wa     = clr_cnt_ff;
            tap_wd     = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == TI_W'(TAPS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               case (job.op)
                  OP_SAMPLE: begin
                     hist_we    = 1'b1;
                     newest_in  = newest_nx;
                     fill_in    = (fill_ff == FC_W'(HIST_LEN)) ? fill_ff
                                                               : fill_ff + 1'b1;
                     dl_in      = dl_fc;
                     dr_in      = dr_fc;
                     addr_l_in  = start_l;
                     addr_r_in  = start_r;
                     tap_cnt_in = '0;
                     acc_l_in   = '0;
                     acc_r_in   = '0;
                     state_in   = ST_MAC;
                  end
                  OP_LOAD_LEFT: begin
                     ltap_we = idx_ok;
                     fill_in = '0;
                  end
                  OP_LOAD_RIGHT: begin
                     rtap_we = idx_ok;
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MAC: begin
            tap_cnt_in = tap_cnt_ff + 1'b1;
            addr_l_in  = (addr_l_ff == '0) ? HA_W'(HIST_LEN - 1) : addr_l_ff - 1'b1;
            addr_r_in  = (addr_r_ff == '0) ? HA_W'(HIST_LEN - 1) : addr_r_ff - 1'b1;
            if (tap_cnt_ff == TI_W'(TAPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               left_out_in  = sat_l;
               right_out_in = sat_r;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         newest_ff    <= '0;
         fill_ff      <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         newest_ff    <= newest_in;
         fill_ff      <= fill_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_cnt_ff   <= tap_cnt_in;
      addr_l_ff    <= addr_l_in;
      addr_r_ff    <= addr_r_in;
      dl_ff        <= dl_in;
      dr_ff        <= dr_in;
      s1_msk_l_ff  <= s1_msk_l_in;
      s1_msk_r_ff  <= s1_msk_r_in;
      prod_l_ff    <= prod_l_in;
      prod_r_ff    <= prod_r_in;
      acc_l_ff     <= acc_l_in;
      acc_r_ff     <= acc_r_in;
      left_out_ff  <= left_out_in;
      right_out_ff <= right_out_in;
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      hist_l_ff <= hist_mem[addr_l_ff];
      hist_r_ff <= hist_mem[addr_r_ff];
   end

   always_ff @(posedge clock) begin
      if (ltap_we) begin
         ltap_mem[tap_wa] <= tap_wd;
      end
      tap_l_ff <= ltap_mem[tap_cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (rtap_we) begin
         rtap_mem[tap_wa] <= tap_wd;
      end
      tap_r_ff <= rtap_mem[tap_cnt_ff];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = left_out_ff;
   assign rsp_right_out = right_out_ff;

endmodule

`default_nettype wire

[hdl/binaural_stereo_fir_convolver.sv]
// binaural_stereo_fir_convolver: top level with delay registers,
// front end (bsfc_front) and convolution back end (bsfc_back); uses bsfc_pkg
//
//   channel  | ports                                   | beat taken when
//   ---------+-----------------------------------------+----------------------------
//   request  | req_cmd, req_tap_index, req_value       | req_valid & req_ready
//   response | rsp_left_out, rsp_right_out             | rsp_valid & rsp_ready
//   csr      | psel penable pwrite paddr pwdata prdata | psel & penable & pwrite
//
// in the back end a sample runs one left and one right
// multiply-accumulate per cycle, one tap address of each tap memory a cycle
// a tap load writes at most one tap entry; an unused command is dropped on arrival
// after reset a pass zeroes both tap memories, req_ready low
// a two-beat queue and the result register let either side stall alone
`default_nettype none

module binaural_stereo_fir_convolver
   import bsfc_pkg::*;
#(
   parameter int TAPS      = 256,
   parameter int MAX_DELAY = 128
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [CMD_W-1:0]         req_cmd,
   input  wire logic [IDX_W-1:0]         req_tap_index,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_left_out,
   output logic signed [DATA_W-1:0]      rsp_right_out,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_W-1:0]    paddr,
   input  wire logic [CSR_W-1:0]         pwdata,
   output logic [CSR_W-1:0]              prdata,
   output logic                          pready
);

   logic [DLY_REG_W-1:0] delay_left_ff, delay_left_in;
   logic [DLY_REG_W-1:0] delay_right_ff, delay_right_in;
   logic                 csr_write;
   logic                 hold;
   logic                 job_valid;
   logic                 job_pop;
   job_type              job;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      delay_left_in  = delay_left_ff;
      delay_right_in = delay_right_ff;
      prdata         = '0;
      unique case (paddr[2])
         REG_DELAY_LEFT: begin
            prdata = CSR_W'(delay_left_ff);
            if (csr_write) begin
               delay_left_in = pwdata[DLY_REG_W-1:0];
            end
         end
         REG_DELAY_RIGHT: begin
            prdata = CSR_W'(delay_right_ff);
            if (csr_write) begin
               delay_right_in = pwdata[DLY_REG_W-1:0];
            end
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_left_ff  <= '0;
         delay_right_ff <= '0;
      end else begin
         delay_left_ff  <= delay_left_in;
         delay_right_ff <= delay_right_in;
      end
   end

   bsfc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_tap_index (req_tap_index),
      .req_value     (req_value),
      .hold          (hold),
      .job_valid     (job_valid),
      .job           (job),
      .job_pop       (job_pop)
   );

   bsfc_back #(
      .TAPS      (TAPS),
      .MAX_DELAY (MAX_DELAY)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job),
      .job_pop       (job_pop),
      .delay_left    (delay_left_ff),
      .delay_right   (delay_right_ff),
      .hold          (hold),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

endmodule

`default_nettype wire

[hdl/bsfc_checker.sv]
// bsfc_checker: port-level assertions for binaural_stereo_fir_convolver
// bound to the top level below; depends on bsfc_pkg for widths
`default_nettype none

module bsfc_checker
   import bsfc_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [DATA_W-1:0] rsp_left_out,
   input wire logic signed [DATA_W-1:0] rsp_right_out,
   input wire logic                     psel,
   input wire logic                     penable,
   input wire logic                     pwrite,
   input wire logic [CSR_ADDR_W-1:0]    paddr,
   input wire logic [CSR_W-1:0]         pwdata,
   input wire logic [CSR_W-1:0]         prdata,
   input wire logic                     pready
);

   // tap clear pass and empty result register right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("beat offered right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_left_out) && $stable(rsp_right_out))
      else $error("result beat changed while stalled");

   a_delay_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && !paddr[2]
      |=> paddr[2] || (prdata[7:0] == $past(pwdata[7:0])))
      else $error("left delay readback differs from write");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind binaural_stereo_fir_convolver bsfc_checker u_bsfc_checker (.*);

`default_nettype wire

[bench/binaural_stereo_fir_convolver_tb.sv]
// binaural_stereo_fir_convolver_tb: self-checking bench for the stereo fir convolver,
// with directed and random test tasks, csr delay writes and a scoreboard of expected pairs
// depends on bsfc_pkg and binaural_stereo_fir_convolver
`timescale 1ns / 100ps

module binaural_stereo_fir_convolver_tb;
   import bsfc_pkg::*;

   localparam int TAPS          = 256;
   localparam int MAX_DELAY     = 128;
   localparam int HIST_LEN      = TAPS + MAX_DELAY;
   localparam int SETTLE_CYCLES = TAPS + 16;
   localparam int HOLD_CYCLES   = 2500;
   localparam int ITEM_TARGET   = 1170;
   localparam int CYCLE_LIMIT   = 2000000;

   typedef struct {
      logic signed [DATA_W-1:0] left;
      logic signed [DATA_W-1:0] right;
   } stereo_pair_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_cmd = CMD_NONE;
   logic [IDX_W-1:0]         req_tap_index = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_left_out;
   logic signed [DATA_W-1:0] rsp_right_out;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    paddr = '0;
   logic [CSR_W-1:0]         pwdata = '0;
   logic [CSR_W-1:0]         prdata;
   logic                     pready;

   // filter state as the block should hold it
   logic signed [DATA_W-1:0] history [HIST_LEN];
   logic signed [DATA_W-1:0] taps_l [TAPS];
   logic signed [DATA_W-1:0] taps_r [TAPS];
   logic [DLY_REG_W-1:0]     delay_l = '0;
   logic [DLY_REG_W-1:0]     delay_r = '0;

   stereo_pair_type pending_pairs [$];
   int         mismatches = 0;
   int         items_sent = 0;
   int         cycle_count = 0;
   int         stall_left = 0;
   bit         req_gaps_on = 1'b1;
   bit         rsp_stalls_on = 1'b1;
   bit         long_hold_request = 1'b0;

   binaural_stereo_fir_convolver #(
      .TAPS      (TAPS),
      .MAX_DELAY (MAX_DELAY)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_tap_index (req_tap_index),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("binaural_stereo_fir_convolver verification failed");
         $finish;
      end
   end

   // one ear: delayed fir over the history, rounded half up and saturated
   function automatic logic signed [DATA_W-1:0] ear_sum(input bit right_ear);
      longint                   acc;
      longint                   q;
      int                       raw;
      int                       d;
      int                       i;
      int                       k;
      logic signed [DATA_W-1:0] coef;
      raw = right_ear ? int'(delay_r) : int'(delay_l);
      d = (raw > MAX_DELAY) ? MAX_DELAY : raw;
      acc = 0;
      for (i = 0; i < TAPS; i++) begin
         k = d + i;
         if (k < HIST_LEN) begin
            coef = right_ear ? taps_r[i] : taps_l[i];
            acc += longint'(coef) * longint'(history[k]);
         end
      end
      q = (acc + 64'sd16384) >>> 15;
      if (q > 32767)
         q = 32767;
      if (q < -32768)
         q = -32768;
      return q[DATA_W-1:0];
   endfunction

   function automatic void advance_filter_state(input logic [CMD_W-1:0] cmd,
                                                input logic [IDX_W-1:0] idx,
                                                input logic signed [DATA_W-1:0] val);
      stereo_pair_type pair;
      int         k;
      case (cmd)
         CMD_SAMPLE: begin
            for (k = HIST_LEN - 1; k > 0; k--)
               history[k] = history[k-1];
            history[0] = val;
            pair.left  = ear_sum(1'b0);
            pair.right = ear_sum(1'b1);
            pending_pairs.push_back(pair);
         end
         CMD_LOAD_LEFT, CMD_LOAD_RIGHT: begin
            if (int'(idx) < TAPS) begin
               if (cmd == CMD_LOAD_LEFT)
                  taps_l[idx] = val;
               else
                  taps_r[idx] = val;
            end
            for (k = 0; k < HIST_LEN; k++)
               history[k] = '0;
         end
         default: ;
      endcase
   endfunction

   function automatic int req_gap();
      int r;
      if (!req_gaps_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_q15(input int max_shift);
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(0, 11))
         0: v = 16'sh7FFF;
         1: v = -16'sh8000;
         2: v = 16'sd0;
         3: v = -16'sd1;
         default: begin
            v = DATA_W'($urandom);
            v = v >>> $urandom_range(0, max_shift);
         end
      endcase
      return v;
   endfunction

   function automatic logic [DLY_REG_W-1:0] rand_delay();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return DLY_REG_W'(MAX_DELAY);
         2: return DLY_REG_W'(MAX_DELAY + 1);
         3: return '1;
         default: return DLY_REG_W'($urandom_range(0, 255));
      endcase
   endfunction

   // offer one beat and wait until it is taken
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] val);
      int gap;
      gap = req_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_tap_index <= idx;
      req_value     <= val;
      do @(posedge clock); while (!req_ready);
      advance_filter_state(cmd, idx, val);
      if (cmd != CMD_NONE)
         items_sent++;
   endtask

   task automatic send_sample(input logic signed [DATA_W-1:0] val);
      send_item(CMD_SAMPLE, IDX_W'($urandom_range(0, 255)), val);
   endtask

   task automatic send_noise();
      send_item(CMD_NONE, IDX_W'($urandom_range(0, 255)), DATA_W'($urandom));
   endtask

   task automatic send_random_load();
      send_item($urandom_range(0, 1) ? CMD_LOAD_LEFT : CMD_LOAD_RIGHT,
                IDX_W'($urandom_range(0, 255)), rand_q15(10));
   endtask

   // stop offering, let every pair come back and any trailing load finish
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pairs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_sel, input logic [DLY_REG_W-1:0] dly);
      logic [CSR_W-1:0] word;
      word = $urandom;
      word[DLY_REG_W-1:0] = dly;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == REG_DELAY_LEFT)
         delay_l = dly;
      else
         delay_r = dly;
      @(posedge clock);
   endtask

   task automatic test_zero_taps();
      send_sample(16'sh7FFF);
      send_noise();
      send_sample(-16'sh8000);
      send_sample(rand_q15(0));
   endtask

   task automatic test_rounding_and_saturation();
      send_item(CMD_LOAD_LEFT, 8'd0, 16'sd1);
      send_item(CMD_LOAD_RIGHT, 8'd0, -16'sh8000);
      // half lsb up, then exact zero, then full-scale negative squared
      send_sample(16'sd16384);
      send_sample(-16'sd16384);
      send_noise();
      send_sample(-16'sh8000);
      send_sample(16'sh7FFF);
      send_item(CMD_LOAD_LEFT, 8'd255, 16'sh7FFF);
      send_item(CMD_LOAD_RIGHT, 8'd255, -16'sh8000);
      send_item(CMD_LOAD_LEFT, 8'd1, 16'sh7FFF);
      send_item(CMD_LOAD_LEFT, 8'd0, 16'sh7FFF);
      send_item(CMD_LOAD_RIGHT, 8'd1, -16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(-16'sh8000);
      send_noise();
      send_sample(16'sd0);
      send_sample(-16'sd1);
   endtask

   task automatic test_delay_settings();
      int n;
      drain();
      csr_write(REG_DELAY_LEFT, 8'd2);
      csr_write(REG_DELAY_RIGHT, 8'd5);
      send_item(CMD_LOAD_LEFT, 8'd0, 16'sd16384);
      send_item(CMD_LOAD_RIGHT, 8'd0, -16'sd16384);
      for (n = 0; n < 10; n++)
         send_sample(rand_q15(2));
   endtask

   task automatic test_backpressure();
      req_gaps_on = 1'b0;
      long_hold_request = 1'b1;
      repeat (16) send_sample(rand_q15(4));
      req_gaps_on = 1'b1;
   endtask

   // long stream so the oldest history entries reach the last taps at full delay
   task automatic test_full_history();
      drain();
      csr_write(REG_DELAY_LEFT, DLY_REG_W'(MAX_DELAY));
      csr_write(REG_DELAY_RIGHT, 8'd255);
      send_item(CMD_LOAD_LEFT, 8'd255, 16'sh4000);
      send_item(CMD_LOAD_RIGHT, 8'd255, -16'sh3000);
      send_item(CMD_LOAD_LEFT, 8'd254, -16'sh2000);
      send_item(CMD_LOAD_RIGHT, 8'd0, 16'sh1000);
      repeat (8) send_random_load();
      repeat (400) send_sample(rand_q15(6));
   endtask

   task automatic test_random_phases();
      int n_loads;
      int n_samples;
      int j;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 3) == 0) begin
            drain();
            csr_write(REG_DELAY_LEFT, rand_delay());
            csr_write(REG_DELAY_RIGHT, rand_delay());
         end
         req_gaps_on   = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         n_loads = $urandom_range(1, 12);
         repeat (n_loads) begin
            if ($urandom_range(0, 9) == 0)
               send_noise();
            send_random_load();
         end
         n_samples = $urandom_range(8, 60);
         repeat (n_samples) begin
            j = $urandom_range(0, 59);
            if (j == 0)
               send_random_load();
            else if (j == 1)
               send_noise();
            send_sample(rand_q15(6));
         end
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // result side: random stalls plus one long hold on request
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (long_hold_request) begin
         long_hold_request = 1'b0;
         stall_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 9) == 0) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each result beat against the oldest expected pair
   always @(posedge clock) begin
      stereo_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pairs.size() == 0) begin
            $error("unexpected beat: left_out %0d right_out %0d",
                   rsp_left_out, rsp_right_out);
            mismatches++;
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_left_out !== want.left) begin
               $error("left_out expected %0d actual %0d", want.left, rsp_left_out);
               mismatches++;
            end
            if (rsp_right_out !== want.right) begin
               $error("right_out expected %0d actual %0d", want.right, rsp_right_out);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int k;
      for (k = 0; k < HIST_LEN; k++)
         history[k] = '0;
      for (k = 0; k < TAPS; k++) begin
         taps_l[k] = '0;
         taps_r[k] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_zero_taps();
      test_rounding_and_saturation();
      test_delay_settings();
      test_backpressure();
      test_full_history();
      test_random_phases();
      drain();
      if (mismatches == 0)
         $display("binaural_stereo_fir_convolver verification clean");
      else
         $display("binaural_stereo_fir_convolver verification failed");
      $finish;
   end

endmodule

[files.f]
hdl/bsfc_pkg.sv
hdl/bsfc_queue.sv
hdl/bsfc_front.sv
hdl/bsfc_back.sv
hdl/binaural_stereo_fir_convolver.sv
hdl/bsfc_checker.sv
bench/binaural_stereo_fir_convolver_tb.sv
